// ===== rtl/assert_macros.svh =====
// assert_macros.svh: assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked at every clock edge out of reset
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/mi3_pkg.sv =====
// ----------------------------------------------------------------------------
// mi3_pkg: shared types and constants for the 3x3 matrix inverse
// Widths of the exact adjugate, determinant and divider datapaths.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package mi3_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EW  = 32;              // element width
  localparam int PW  = 2 * EW;          // element product
  localparam int AW  = PW + 1;          // adjugate entry, signed
  localparam int AMW = PW;              // adjugate magnitude
  localparam int DW  = 98;              // determinant, signed
  localparam int MW  = DW - 1;          // determinant magnitude
  localparam int QW  = EW + 1;          // quotient bits kept
  localparam int NW  = AMW + 2 * FRAC_BITS;  // dividend width
  localparam int RW  = NW - QW;         // initial partial remainder
  localparam int LANES = 9;
  localparam int PRE_STAGES = 7;

  // adjugate entry i = m[a]*m[b] - m[c]*m[d]
  localparam int COF_IDX [LANES][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef logic signed [EW-1:0] elem_t;

  typedef struct packed {
    elem_t e00; elem_t e01; elem_t e02;
    elem_t e10; elem_t e11; elem_t e12;
    elem_t e20; elem_t e21; elem_t e22;
  } in_item_t;

  typedef struct packed {
    elem_t r00; elem_t r01; elem_t r02;
    elem_t r10; elem_t r11; elem_t r12;
    elem_t r20; elem_t r21; elem_t r22;
    logic  singular;
    logic  clipped;
  } out_item_t;

endpackage

// ===== rtl/mi3_stream_if.sv =====
// ----------------------------------------------------------------------------
// mi3_stream_if: valid/ready channels for matrices and inverses
// A transfer happens on a clock edge with valid and ready both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface mi3_in_if;
  logic             valid;
  logic             ready;
  mi3_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mi3_out_if;
  logic              valid;
  logic              ready;
  mi3_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/mi3_div.sv =====
// ----------------------------------------------------------------------------
// mi3_div: pipelined restoring divider lane
// One quotient bit per stage, QW stages; sign and overflow ride along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module mi3_div (
  input  logic                    clk,
  input  logic                    en,
  input  logic [mi3_pkg::RW-1:0]  rem0,
  input  logic [mi3_pkg::QW-1:0]  nlo,
  input  logic [mi3_pkg::MW-1:0]  den,
  input  logic                    neg,
  input  logic                    ovf,
  output logic [mi3_pkg::QW-1:0]  quo,
  output logic                    quo_neg,
  output logic                    quo_ovf
);
  import mi3_pkg::*;

  logic [MW-1:0] rem_w [QW+1];
  logic [QW-1:0] nlo_w [QW+1];
  logic [QW-1:0] q_w   [QW+1];
  logic [MW-1:0] den_w [QW+1];
  logic          neg_w [QW+1];
  logic          ovf_w [QW+1];

  assign rem_w[0] = {{(MW-RW){1'b0}}, rem0};
  assign nlo_w[0] = nlo;
  assign q_w[0]   = '0;
  assign den_w[0] = den;
  assign neg_w[0] = neg;
  assign ovf_w[0] = ovf;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [MW-1:0] rem_r;
    logic [QW-1:0] nlo_r, q_r;
    logic [MW-1:0] den_r;
    logic          neg_r, ovf_r;
    logic [MW:0]   r2, diff;
    logic          ge;

    always_comb begin
      r2   = {rem_w[k], nlo_w[k][QW-1]};
      diff = r2 - {1'b0, den_w[k]};
      ge   = r2 >= {1'b0, den_w[k]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r <= ge ? diff[MW-1:0] : r2[MW-1:0];
        nlo_r <= {nlo_w[k][QW-2:0], 1'b0};
        q_r   <= {q_w[k][QW-2:0], ge};
        den_r <= den_w[k];
        neg_r <= neg_w[k];
        ovf_r <= ovf_w[k];
      end
    end

    assign rem_w[k+1] = rem_r;
    assign nlo_w[k+1] = nlo_r;
    assign q_w[k+1]   = q_r;
    assign den_w[k+1] = den_r;
    assign neg_w[k+1] = neg_r;
    assign ovf_w[k+1] = ovf_r;
  end

  assign quo     = q_w[QW];
  assign quo_neg = neg_w[QW];
  assign quo_ovf = ovf_w[QW];

endmodule

// ===== rtl/matrix3_inverse.sv =====
// Pipeline: 41 register stages (7 setup stages, 33 divider stages, one output
// register) lie between an input transfer and its result.
// Throughput: one matrix per cycle, set by the fully pipelined multipliers and
// the nine one-bit-per-stage divider lanes; an output stall freezes the pipe.
// Reset clears all valid bits and holds ready low; data registers are not reset.
// ----------------------------------------------------------------------------
// matrix3_inverse: 3x3 Q16.16 inverse by adjugate and determinant
// Exact cofactors, exact determinant, truncating divide, saturated result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module matrix3_inverse (
  input  logic clk,
  input  logic rst_n,
  mi3_in_if.sink    in_ch,
  mi3_out_if.source out_ch
);
  import mi3_pkg::*;

  localparam int NST = PRE_STAGES + QW;

  logic adv;
  logic [NST-1:0] vld_r;
  logic [QW-1:0]  zero_r;
  logic           out_vld_r;
  out_item_t      out_data_r;

  assign adv         = !out_vld_r || out_ch.ready;
  assign in_ch.ready = adv && rst_n;

  elem_t m [LANES];
  assign m[0] = in_ch.data.e00; assign m[1] = in_ch.data.e01;
  assign m[2] = in_ch.data.e02; assign m[3] = in_ch.data.e10;
  assign m[4] = in_ch.data.e11; assign m[5] = in_ch.data.e12;
  assign m[6] = in_ch.data.e20; assign m[7] = in_ch.data.e21;
  assign m[8] = in_ch.data.e22;

  // stage 1: products; stage 2: adjugate
  logic signed [PW-1:0] pa_r [LANES];
  logic signed [PW-1:0] pb_r [LANES];
  elem_t                m1_r [3];
  elem_t                m2_r [3];
  logic signed [AW-1:0] adj_r [LANES];
  // stage 3..6 carry
  logic signed [AW:0]   pph_r [3];
  logic signed [AW:0]   ppl_r [3];
  logic signed [DW-1:0] dp_r  [3];
  logic signed [DW-1:0] det_r;
  logic [MW-1:0]        dabs_r;
  logic                 dneg_r, dzero_r;
  logic [AMW-1:0]       aabs3_r [LANES], aabs4_r [LANES], aabs5_r [LANES], aabs6_r [LANES];
  logic                 aneg3_r [LANES], aneg4_r [LANES], aneg5_r [LANES], aneg6_r [LANES];
  // stage 7: divider launch
  logic [RW-1:0]        rem0_r [LANES];
  logic [QW-1:0]        nlo_r  [LANES];
  logic                 neg7_r [LANES];
  logic                 ovf7_r [LANES];
  logic [MW-1:0]        den7_r;
  logic                 zero7_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        pa_r[i]  <= m[COF_IDX[i][0]] * m[COF_IDX[i][1]];
        pb_r[i]  <= m[COF_IDX[i][2]] * m[COF_IDX[i][3]];
        adj_r[i] <= {pa_r[i][PW-1], pa_r[i]} - {pb_r[i][PW-1], pb_r[i]};
      end
      for (int k = 0; k < 3; k++) begin
        m1_r[k]  <= m[3*k];
        m2_r[k]  <= m1_r[k];
        pph_r[k] <= m2_r[k] * $signed(adj_r[k][AW-1:EW]);
        ppl_r[k] <= m2_r[k] * $signed({1'b0, adj_r[k][EW-1:0]});
        dp_r[k]  <= {pph_r[k], {EW{1'b0}}}
                  + {{(DW-AW-1){ppl_r[k][AW]}}, ppl_r[k]};
      end
      det_r <= dp_r[0] + dp_r[1] + dp_r[2];
    end
  end

  logic signed [AW-1:0] adj_mag [LANES];
  logic signed [DW-1:0] det_mag;
  logic [NW-1:0]        num [LANES];

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      adj_mag[i] = adj_r[i][AW-1] ? -adj_r[i] : adj_r[i];
      num[i]     = {aabs6_r[i], {(2*FRAC_BITS){1'b0}}};
    end
    det_mag = det_r[DW-1] ? -det_r : det_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < LANES; i++) begin
        aabs3_r[i] <= adj_mag[i][AMW-1:0];
        aneg3_r[i] <= adj_r[i][AW-1];
        aabs4_r[i] <= aabs3_r[i]; aneg4_r[i] <= aneg3_r[i];
        aabs5_r[i] <= aabs4_r[i]; aneg5_r[i] <= aneg4_r[i];
        aabs6_r[i] <= aabs5_r[i]; aneg6_r[i] <= aneg5_r[i];
        rem0_r[i]  <= num[i][NW-1:QW];
        nlo_r[i]   <= num[i][QW-1:0];
        neg7_r[i]  <= aneg6_r[i] ^ dneg_r;
        // quotient reaches 2^QW when the top dividend bits already cover den
        ovf7_r[i]  <= {{(MW-RW){1'b0}}, num[i][NW-1:QW]} >= dabs_r;
      end
      dabs_r  <= det_mag[MW-1:0];
      dneg_r  <= det_r[DW-1];
      dzero_r <= det_r == '0;
      den7_r  <= dabs_r;
      zero7_r <= dzero_r;
    end
  end

  logic [QW-1:0] quo     [LANES];
  logic          quo_neg [LANES];
  logic          quo_ovf [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    mi3_div u_div (
      .clk     (clk),
      .en      (adv),
      .rem0    (rem0_r[i]),
      .nlo     (nlo_r[i]),
      .den     (den7_r),
      .neg     (neg7_r[i]),
      .ovf     (ovf7_r[i]),
      .quo     (quo[i]),
      .quo_neg (quo_neg[i]),
      .quo_ovf (quo_ovf[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_r <= {zero_r[QW-2:0], zero7_r};
    end
  end

  // saturation and singular override
  elem_t r_sat [LANES];
  logic  clip_any;
  logic  big;

  always_comb begin
    clip_any = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      if (!quo_neg[i]) begin
        big      = quo_ovf[i] || (quo[i] > QW'(33'h07FFFFFFF));
        r_sat[i] = big ? 32'sh7FFFFFFF : quo[i][EW-1:0];
      end else begin
        big      = quo_ovf[i] || (quo[i] > QW'(33'h080000000));
        r_sat[i] = big ? 32'sh80000000 : (~quo[i][EW-1:0] + 32'd1);
      end
      clip_any = clip_any | big;
      if (zero_r[QW-1]) begin
        r_sat[i] = '0;
      end
    end
    if (zero_r[QW-1]) begin
      clip_any = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[NST-2:0], in_ch.valid};
      out_vld_r <= vld_r[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r.r00      <= r_sat[0];
      out_data_r.r01      <= r_sat[1];
      out_data_r.r02      <= r_sat[2];
      out_data_r.r10      <= r_sat[3];
      out_data_r.r11      <= r_sat[4];
      out_data_r.r12      <= r_sat[5];
      out_data_r.r20      <= r_sat[6];
      out_data_r.r21      <= r_sat[7];
      out_data_r.r22      <= r_sat[8];
      out_data_r.singular <= zero_r[QW-1];
      out_data_r.clipped  <= clip_any;
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_data_r;

  `ASSERT_IMPLIES(a_singular_zero, clk, rst_n, out_vld_r && out_data_r.singular,
    (out_data_r.r00 == '0) && (out_data_r.r11 == '0) && (out_data_r.r22 == '0)
    && !out_data_r.clipped)
  `ASSERT_IMPLIES(a_clip_value, clk, rst_n, out_vld_r && out_data_r.clipped,
    (out_data_r.r00 == 32'sh7FFFFFFF) || (out_data_r.r00 == 32'sh80000000) ||
    (out_data_r.r01 == 32'sh7FFFFFFF) || (out_data_r.r01 == 32'sh80000000) ||
    (out_data_r.r02 == 32'sh7FFFFFFF) || (out_data_r.r02 == 32'sh80000000) ||
    (out_data_r.r10 == 32'sh7FFFFFFF) || (out_data_r.r10 == 32'sh80000000) ||
    (out_data_r.r11 == 32'sh7FFFFFFF) || (out_data_r.r11 == 32'sh80000000) ||
    (out_data_r.r12 == 32'sh7FFFFFFF) || (out_data_r.r12 == 32'sh80000000) ||
    (out_data_r.r20 == 32'sh7FFFFFFF) || (out_data_r.r20 == 32'sh80000000) ||
    (out_data_r.r21 == 32'sh7FFFFFFF) || (out_data_r.r21 == 32'sh80000000) ||
    (out_data_r.r22 == 32'sh7FFFFFFF) || (out_data_r.r22 == 32'sh80000000))
  `ASSERT_NEXT(a_pipe_hold, clk, rst_n, out_vld_r && !out_ch.ready,
    (vld_r == $past(vld_r)) && (zero_r == $past(zero_r)))

endmodule

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking testbench for matrix3_inverse
// A directed table, then random matrices under four idle/stall phases. Each result
// is checked field by field against a typed answer or an exact wide-integer inverse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import mi3_pkg::*;

  localparam int  LIMIT   = 400000;
  localparam int  DRAIN   = 60;
  localparam elem_t ONE   = 32'sh0001_0000;
  localparam elem_t MAXV  = 32'sh7FFF_FFFF;
  localparam elem_t MINV  = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mi3_in_if  in_bus ();
  mi3_out_if out_bus ();

  matrix3_inverse dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int         cycles = 0;
  int         errors = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  out_item_t  pending_inv[$];

  function automatic out_item_t inverse_of(in_item_t x);
    logic signed [127:0] m [9];
    logic signed [127:0] adj [9];
    logic signed [127:0] det;
    logic [127:0] den, mag, q;
    logic [31:0] v [9];
    bit neg, clip;
    m[0] = x.e00; m[1] = x.e01; m[2] = x.e02;
    m[3] = x.e10; m[4] = x.e11; m[5] = x.e12;
    m[6] = x.e20; m[7] = x.e21; m[8] = x.e22;
    adj[0] = m[4] * m[8] - m[5] * m[7];
    adj[1] = m[2] * m[7] - m[1] * m[8];
    adj[2] = m[1] * m[5] - m[2] * m[4];
    adj[3] = m[5] * m[6] - m[3] * m[8];
    adj[4] = m[0] * m[8] - m[2] * m[6];
    adj[5] = m[2] * m[3] - m[0] * m[5];
    adj[6] = m[3] * m[7] - m[4] * m[6];
    adj[7] = m[1] * m[6] - m[0] * m[7];
    adj[8] = m[0] * m[4] - m[1] * m[3];
    det = m[0] * adj[0] + m[3] * adj[1] + m[6] * adj[2];
    if (det == 0) begin
      return {{LANES{32'h0}}, 1'b1, 1'b0};
    end
    clip = 1'b0;
    den = det[127] ? -det : det;
    for (int i = 0; i < LANES; i++) begin
      neg = adj[i][127] != det[127];
      mag = adj[i][127] ? -adj[i] : adj[i];
      q = (mag << (2 * FRAC_BITS)) / den;
      if (!neg) begin
        if (q > 128'h7FFF_FFFF) begin
          v[i] = 32'h7FFF_FFFF; clip = 1'b1;
        end else begin
          v[i] = q[31:0];
        end
      end else begin
        if (q > 128'h8000_0000) begin
          v[i] = 32'h8000_0000; clip = 1'b1;
        end else begin
          v[i] = -q[31:0];
        end
      end
    end
    return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8], 1'b0, clip};
  endfunction

  function automatic in_item_t mat(elem_t a, elem_t b, elem_t c, elem_t d, elem_t e,
                                   elem_t f, elem_t g, elem_t h, elem_t k);
    return {a, b, c, d, e, f, g, h, k};
  endfunction

  // input monitor: record the expected inverse of each accepted matrix
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready)
      pending_inv.push_back(inverse_of(in_bus.data));
  end

  // directed rows with a typed answer replace the predicted one
  bit        typed_q[$];
  out_item_t typed_val[$];
  int        typed_seen = 0;
  logic [31:0] exp_e [LANES];
  logic [31:0] got_e [LANES];
  string       lane_name [LANES] = '{"r00", "r01", "r02", "r10", "r11", "r12",
                                     "r20", "r21", "r22"};

  always @(posedge clk) begin
    out_item_t want, got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got = out_bus.data;
      if (pending_inv.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        want = pending_inv.pop_front();
        if (typed_seen < typed_q.size()) begin
          if (typed_q[typed_seen]) want = typed_val[typed_seen];
          typed_seen++;
        end
        {exp_e[0], exp_e[1], exp_e[2], exp_e[3], exp_e[4], exp_e[5], exp_e[6],
         exp_e[7], exp_e[8]} = want[9*EW+1:2];
        {got_e[0], got_e[1], got_e[2], got_e[3], got_e[4], got_e[5], got_e[6],
         got_e[7], got_e[8]} = got[9*EW+1:2];
        for (int i = 0; i < LANES; i++) begin
          if (got_e[i] !== exp_e[i]) begin
            $error("%s: expected %h, got %h", lane_name[i], exp_e[i], got_e[i]);
            errors++;
          end
        end
        if (got.singular !== want.singular) begin
          $error("singular: expected %b, got %b", want.singular, got.singular);
          errors++;
        end
        if (got.clipped !== want.clipped) begin
          $error("clipped: expected %b, got %b", want.clipped, got.clipped);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send(in_item_t item);
    while ($urandom_range(99) < idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.data  <= item;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  function automatic elem_t pick_extreme();
    case ($urandom_range(6))
      0: return MAXV;
      1: return MINV;
      2: return 32'sh0;
      3: return 32'sh1;
      4: return -32'sh1;
      5: return ONE;
      default: return -ONE;
    endcase
  endfunction

  function automatic elem_t pick_small();
    return elem_t'($signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000);
  endfunction

  function automatic in_item_t random_matrix();
    elem_t r [9];
    int s;
    case ($urandom_range(9))
      0, 1: for (int i = 0; i < 9; i++) r[i] = $urandom;
      2, 3, 4: for (int i = 0; i < 9; i++) r[i] = pick_small();
      5: for (int i = 0; i < 9; i++) r[i] = pick_extreme();
      6: begin
        // duplicated row (scaled by a small integer): singular
        for (int i = 0; i < 6; i++) r[i] = pick_small();
        s = $urandom_range(3) - 1;
        for (int i = 0; i < 3; i++) r[6 + i] = r[3 + i] * s;
      end
      7: begin
        for (int i = 0; i < 9; i++) r[i] = 32'sh0;
        r[0] = $urandom; r[4] = $urandom; r[8] = $urandom;
      end
      default: begin
        // near-identity, well conditioned
        for (int i = 0; i < 9; i++)
          r[i] = elem_t'($signed($urandom_range(32'h0000_4000)) - 32'sh2000);
        r[0] += ONE; r[4] += ONE; r[8] += ONE;
      end
    endcase
    return mat(r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]);
  endfunction

  in_item_t  dir_in [$];
  bit        dir_typed [$];
  out_item_t dir_out [$];

  task automatic add_row(in_item_t m, bit has, out_item_t o);
    dir_in.push_back(m);
    dir_typed.push_back(has);
    dir_out.push_back(o);
  endtask

  initial begin
    out_item_t none;
    none = '0;
    in_bus.valid = 1'b0;
    in_bus.data  = '0;
    out_bus.ready = 1'b0;

    add_row(mat(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE), 1,
            {ONE, 32'h0, 32'h0, 32'h0, ONE, 32'h0, 32'h0, 32'h0, ONE, 1'b0, 1'b0});
    add_row('0, 1, {{LANES{32'h0}}, 1'b1, 1'b0});
    add_row({9{MAXV}}, 1, {{LANES{32'h0}}, 1'b1, 1'b0});
    add_row({9{MINV}}, 1, {{LANES{32'h0}}, 1'b1, 1'b0});
    add_row(mat(1, 0, 0, 0, 1, 0, 0, 0, 1), 1,
            {MAXV, 32'h0, 32'h0, 32'h0, MAXV, 32'h0, 32'h0, 32'h0, MAXV, 1'b0, 1'b1});
    add_row(mat(-1, 0, 0, 0, -1, 0, 0, 0, -1), 1,
            {MINV, 32'h0, 32'h0, 32'h0, MINV, 32'h0, 32'h0, 32'h0, MINV, 1'b0, 1'b1});
    add_row(mat(MAXV, 0, 0, 0, MAXV, 0, 0, 0, MAXV), 0, none);
    add_row(mat(MINV, 0, 0, 0, MINV, 0, 0, 0, MINV), 0, none);
    add_row(mat(MINV, MAXV, 0, MAXV, MINV, 0, 0, 0, ONE), 0, none);
    add_row(mat(0, ONE, 0, ONE, 0, 0, 0, 0, ONE), 0, none);
    add_row(mat(2 * ONE, ONE, 0, ONE, 3 * ONE, ONE, 0, ONE, 4 * ONE), 0, none);
    add_row(mat(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                7 * ONE, 8 * ONE, 9 * ONE), 0, none);
    add_row(mat(-ONE, 0, 0, 0, 2 * ONE, 0, 0, 0, -4 * ONE), 0, none);
    add_row(mat(MAXV, MINV, MAXV, MINV, MAXV, MINV, 1, -1, 1), 0, none);
    add_row(mat(32'h5555_5555, 32'hAAAA_AAAA, 1, 2, 32'h5555_5555, 32'hAAAA_AAAA,
                32'hAAAA_AAAA, 3, 32'h5555_5555), 0, none);
    add_row(mat(0, 0, ONE, 0, ONE, 0, ONE, 0, 0), 0, none);
    for (int i = 0; i < dir_in.size(); i++) begin
      typed_q.push_back(dir_typed[i]);
      typed_val.push_back(dir_out[i]);
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_in[i]) send(dir_in[i]);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 45; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 45; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      for (int n = 0; n < 175; n++) send(random_matrix());
    end
    in_bus.valid <= 1'b0;
    stall_pct = 0;

    while (pending_inv.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
